// ===== src/sha256_pkg.sv =====
// Package with SHA-256 constants, types and round functions.
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned DigestWords = 8;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenSlot = 6'd56;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } state_t;

  // Control between the sequencer and the round unit.
  typedef struct packed {
    logic       init;   // load working vars from the chaining state
    logic       round;  // perform one round
    logic       fold;   // add working vars into the chaining state
    logic       reset_h; // restore initial hash values
    logic [5:0] rnd;    // round number
  } rnd_ctl_t;

  function automatic word_t init_hash(input logic [2:0] i);
    case (i)
      3'd0: return 32'h6a09e667;
      3'd1: return 32'hbb67ae85;
      3'd2: return 32'h3c6ef372;
      3'd3: return 32'ha54ff53a;
      3'd4: return 32'h510e527f;
      3'd5: return 32'h9b05688c;
      3'd6: return 32'h1f83d9ab;
      default: return 32'h5be0cd19;
    endcase
  endfunction

  function automatic word_t round_k(input logic [5:0] i);
    word_t k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    return k[i];
  endfunction

  function automatic word_t ror(input word_t v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

endpackage

// ===== src/sha256_if.sv =====
// Valid/ready channel interfaces for message bytes and digest words.
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;
  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, hash_word, word_index, last_word, input ready);
  modport sink (input valid, hash_word, word_index, last_word, output ready);
endinterface

// ===== src/sha256_round.sv =====
// Shared round unit: message schedule window, working variables, chaining state.
module sha256_round
  import sha256_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  rnd_ctl_t   ctl,
  input  word_t      w_new,   // block word for rounds 0..15
  input  logic [2:0] rd_idx,
  output word_t      rd_word
);

  word_t h_r [8];
  word_t v_r [8];
  word_t w_r [16];   // sliding schedule window, w_r[0] is oldest

  word_t w_cur, s0, s1, big0, big1, ch, maj, t1;

  // Schedule word for this round.
  always_comb begin
    s0 = ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10);
    w_cur = (ctl.rnd < 6'd16) ? w_new : (s1 + w_r[9] + s0 + w_r[0]);
    big1 = ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25);
    ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1   = v_r[7] + big1 + ch + round_k(ctl.rnd) + w_cur;
    big0 = ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22);
    maj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  end

  // Working variables and schedule window.
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (ctl.round) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + big0 + maj;
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_cur;
    end
  end

  // Chaining state.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.reset_h) begin
      for (int i = 0; i < 8; i++) h_r[i] <= init_hash(3'(i));
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

  assign rd_word = h_r[rd_idx];

endmodule

// ===== src/sha256_hash_engine_unit.sv =====
// Top level of the SHA-256 byte-stream hash engine.
// One item carries an optional message byte and an end-of-message flag. A byte
// that does not complete a 64-byte block leaves the engine ready unless the item
// ends the message. A completing byte starts compression in the shared round
// unit: a load step, 64 rounds (one round per cycle) and a fold step, during
// which no item is accepted. On end of message the sequencer writes the pad
// byte, zeros and the 64-bit bit count one byte per cycle between compressions
// (up to 72 bytes, one or two compressions), then offers the eight digest words,
// index 0 first, one per cycle while the receiver is ready, with last_word on
// the eighth; the hash then returns to its initial value for the next message.
module sha256_hash_engine_unit
  import sha256_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);

  state_t      state_r, state_nxt;
  word_t       buf_r [16];
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt, len_r, len_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic        fin_r, fin_nxt;       // padding in progress
  logic        pad_r, pad_nxt;       // pad byte already written
  logic        lok_r, lok_nxt;       // this block receives the bit count
  logic        padded_r, padded_nxt; // bit count written
  logic [2:0]  oidx_r, oidx_nxt;
  logic        wr_en;
  logic [7:0]  wr_byte;
  rnd_ctl_t    ctl;
  word_t       w_rd_r, hw;
  logic [3:0]  baddr;

  sha256_round u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .w_new  (w_rd_r),
    .rd_idx (oidx_r),
    .rd_word(hw)
  );

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    bits_nxt   = bits_r;
    len_nxt    = len_r;
    rnd_nxt    = rnd_r;
    fin_nxt    = fin_r;
    pad_nxt    = pad_r;
    lok_nxt    = lok_r;
    padded_nxt = padded_r;
    oidx_nxt   = oidx_r;
    wr_en      = 1'b0;
    wr_byte    = 8'h00;
    ctl        = '0;
    ctl.rnd    = rnd_r;
    in_ch.ready = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          fin_nxt = in_ch.end_of_message;
          len_nxt = bits_r + (in_ch.has_byte ? 64'd8 : 64'd0);
          if (in_ch.has_byte) begin
            wr_en    = 1'b1;
            wr_byte  = in_ch.data_byte;
            bits_nxt = bits_r + 64'd8;
            fill_nxt = fill_r + 6'd1;
            if (fill_r == 6'd63) state_nxt = ST_LOAD;
            else if (in_ch.end_of_message) state_nxt = ST_PAD;
          end else if (in_ch.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // Pad byte first, then zeros, with the bit count in the last eight slots
        // of the block that has room for it.
        wr_en = 1'b1;
        if (!pad_r) begin
          wr_byte = PadByte;
          pad_nxt = 1'b1;
          if (fill_r < LenSlot) lok_nxt = 1'b1;
        end else if (lok_r && fill_r >= LenSlot) begin
          wr_byte = len_r[{~fill_r[2:0], 3'b111} -: 8];
        end else begin
          wr_byte = 8'h00;
        end
        fill_nxt = fill_r + 6'd1;
        if (fill_r == 6'd63) begin
          state_nxt = ST_LOAD;
          if (pad_r && lok_r) padded_nxt = 1'b1;
        end
      end
      ST_LOAD: begin
        ctl.init  = 1'b1;
        rnd_nxt   = 6'd0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        ctl.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'(Rounds - 1)) state_nxt = ST_ADD;
      end
      ST_ADD: begin
        ctl.fold = 1'b1;
        // A finish goes on padding until the bit count has been compressed;
        // a block after the pad byte always has room for the count.
        if (!fin_r) state_nxt = ST_IDLE;
        else if (padded_r) state_nxt = ST_EMIT;
        else begin
          state_nxt = ST_PAD;
          if (pad_r) lok_nxt = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_ch.ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'(DigestWords - 1)) begin
            ctl.reset_h = 1'b1;
            bits_nxt   = 64'd0;
            fill_nxt   = 6'd0;
            fin_nxt    = 1'b0;
            pad_nxt    = 1'b0;
            lok_nxt    = 1'b0;
            padded_nxt = 1'b0;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= 6'd0;
      bits_r   <= 64'd0;
      len_r    <= 64'd0;
      rnd_r    <= 6'd0;
      fin_r    <= 1'b0;
      pad_r    <= 1'b0;
      lok_r    <= 1'b0;
      oidx_r   <= 3'd0;
      padded_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      bits_r   <= bits_nxt;
      len_r    <= len_nxt;
      rnd_r    <= rnd_nxt;
      fin_r    <= fin_nxt;
      pad_r    <= pad_nxt;
      lok_r    <= lok_nxt;
      oidx_r   <= oidx_nxt;
      padded_r <= padded_nxt;
    end
  end

  // Block buffer of sixteen big-endian words, filled one byte lane at a time.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (fill_r[1:0])
        2'd0: buf_r[fill_r[5:2]][31:24] <= wr_byte;
        2'd1: buf_r[fill_r[5:2]][23:16] <= wr_byte;
        2'd2: buf_r[fill_r[5:2]][15:8]  <= wr_byte;
        default: buf_r[fill_r[5:2]][7:0] <= wr_byte;
      endcase
    end
  end

  // Registered word read, one word ahead of the round that uses it.
  assign baddr = (state_r == ST_ROUND) ? rnd_r[3:0] + 4'd1 : 4'd0;

  always_ff @(posedge clk) begin
    w_rd_r <= buf_r[baddr];
  end

  assign out_ch.valid      = (state_r == ST_EMIT);
  assign out_ch.hash_word  = hw;
  assign out_ch.word_index = oidx_r;
  assign out_ch.last_word  = (oidx_r == 3'(DigestWords - 1));

endmodule
